// ----- sv/parp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package parp_pkg;

    localparam int HdrBytes = 28;
    localparam int CountW = 5;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] HW_IEEE802 = 16'h0006;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY = 16'h0002;
    localparam logic [7:0] MAC_LEN = 8'd6;
    localparam logic [7:0] IP_LEN = 8'd4;

    localparam logic [1:0] VERDICT_IGNORE = 2'd0;
    localparam logic [1:0] VERDICT_REPLY = 2'd1;
    localparam logic [1:0] VERDICT_LEARN = 2'd2;

    localparam int CfgIndexW = 2;
    localparam logic [CfgIndexW-1:0] CFG_WAN_ADDRESS = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_LAN_MASK = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_GATEWAY_ADDRESS = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] reply_sender_ip;
        logic [31:0] reply_target_ip;
        logic [47:0] peer_mac;
    } out_beat_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [15:0]       hw_type;
        logic [15:0]       proto_type;
        logic [7:0]        hw_len;
        logic [7:0]        proto_len;
        logic [15:0]       opcode;
        logic [47:0]       sender_mac;
        logic [31:0]       sender_ip;
        logic [31:0]       target_ip;
    } hdr_t;

    function automatic logic [1:0] judge(input hdr_t h, input logic [31:0] wan,
                                         input logic [31:0] mask, input logic [31:0] gw);
        logic [1:0] v;
        v = VERDICT_IGNORE;
        if (h.count == CountW'(HdrBytes) &&
            (h.hw_type == HW_ETHERNET || h.hw_type == HW_IEEE802) &&
            h.proto_type == PROTO_IPV4 && h.hw_len == MAC_LEN && h.proto_len == IP_LEN &&
            h.sender_ip != 32'd0) begin
            if (h.opcode == OP_REQUEST) begin
                if (wan == 32'd0) begin
                    if (h.sender_ip != h.target_ip) begin
                        v = VERDICT_REPLY;
                    end
                end else if (h.sender_ip == wan && (h.target_ip & mask) == (wan & mask) &&
                             h.target_ip != wan) begin
                    v = VERDICT_REPLY;
                end
            end else if (h.opcode == OP_REPLY) begin
                if (h.sender_ip == wan && h.target_ip == gw) begin
                    v = VERDICT_LEARN;
                end
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/parp_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none

module parp_capture (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire parp_pkg::in_beat_t beat,
    output parp_pkg::hdr_t        hdr_view
);
    import parp_pkg::*;

    hdr_t hdr_reg;
    hdr_t hdr_next;
    hdr_t hdr_store;

    // The view includes the byte on the input, so the last byte is judged at once.
    always_comb begin
        hdr_next = hdr_reg;
        if (hdr_reg.count < CountW'(HdrBytes)) begin
            hdr_next.count = hdr_reg.count + CountW'(1);
            if (hdr_reg.count < CountW'(2)) begin
                hdr_next.hw_type = {hdr_reg.hw_type[7:0], beat.data_byte};
            end else if (hdr_reg.count < CountW'(4)) begin
                hdr_next.proto_type = {hdr_reg.proto_type[7:0], beat.data_byte};
            end else if (hdr_reg.count == CountW'(4)) begin
                hdr_next.hw_len = beat.data_byte;
            end else if (hdr_reg.count == CountW'(5)) begin
                hdr_next.proto_len = beat.data_byte;
            end else if (hdr_reg.count < CountW'(8)) begin
                hdr_next.opcode = {hdr_reg.opcode[7:0], beat.data_byte};
            end else if (hdr_reg.count < CountW'(14)) begin
                hdr_next.sender_mac = {hdr_reg.sender_mac[39:0], beat.data_byte};
            end else if (hdr_reg.count < CountW'(18)) begin
                hdr_next.sender_ip = {hdr_reg.sender_ip[23:0], beat.data_byte};
            end else if (hdr_reg.count >= CountW'(24)) begin
                hdr_next.target_ip = {hdr_reg.target_ip[23:0], beat.data_byte};
            end
        end
    end

    always_comb begin
        hdr_store = hdr_next;
        if (beat.last_byte) begin
            hdr_store.count = '0;
        end
    end

    assign hdr_view = hdr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= '0;
        end else if (take) begin
            hdr_reg <= hdr_store;
        end
    end

endmodule

`default_nettype wire

// ----- sv/proxy_arp_responder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Beat
// s_        in         s_valid / s_ready  one ARP byte with a last flag
// m_        out        m_valid / m_ready  verdict, reply addresses and peer MAC
// cfg_      in         cfg_wr_en          register write, no back-pressure
//
// One byte is taken per cycle unless stalled; results register on the last byte.
// A result waits in the output register, and the input stalls only while it waits.
// Reset clears the byte counter, the output valid flag and the learned client.

module proxy_arp_responder_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire parp_pkg::in_beat_t               s_payload,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output parp_pkg::out_beat_t                   m_payload,
    input  wire logic                             cfg_wr_en,
    input  wire logic [parp_pkg::CfgIndexW-1:0]   cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import parp_pkg::*;

    logic [31:0] wan_reg;
    logic [31:0] mask_reg;
    logic [31:0] gateway_reg;
    logic        m_valid_reg;
    out_beat_t   m_beat_reg;
    out_beat_t   m_beat_next;
    logic [47:0] client_mac_reg;
    logic        client_known_reg;
    logic        take;
    hdr_t        hdr_view;
    logic [1:0]  verdict;

    assign s_ready = !m_valid_reg || m_ready;
    assign take = s_valid && s_ready;

    parp_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .beat     (s_payload),
        .hdr_view (hdr_view)
    );

    always_comb begin
        verdict = judge(hdr_view, wan_reg, mask_reg, gateway_reg);
        m_beat_next = '0;
        m_beat_next.verdict = verdict;
        if (verdict == VERDICT_REPLY) begin
            m_beat_next.reply_sender_ip = hdr_view.target_ip;
            m_beat_next.reply_target_ip = wan_reg;
        end
        if (verdict != VERDICT_IGNORE) begin
            m_beat_next.peer_mac = hdr_view.sender_mac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wan_reg <= '0;
            mask_reg <= '0;
            gateway_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WAN_ADDRESS: wan_reg <= cfg_data;
                CFG_LAN_MASK: mask_reg <= cfg_data;
                CFG_GATEWAY_ADDRESS: gateway_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            client_known_reg <= 1'b0;
            client_mac_reg <= '0;
        end else begin
            if (take && s_payload.last_byte) begin
                m_valid_reg <= 1'b1;
                if (verdict != VERDICT_IGNORE) begin
                    client_known_reg <= 1'b1;
                    client_mac_reg <= hdr_view.sender_mac;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_payload.last_byte) begin
            m_beat_reg <= m_beat_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_payload = m_beat_reg;

    a_learned_matches : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.verdict != VERDICT_IGNORE)
        |-> (client_known_reg && client_mac_reg == m_beat_reg.peer_mac))
        else $error("learned client differs from the reported peer");

    a_verdict_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_beat_reg.verdict == VERDICT_IGNORE ||
                         m_beat_reg.verdict == VERDICT_REPLY ||
                         m_beat_reg.verdict == VERDICT_LEARN))
        else $error("undefined verdict code");

    a_ignore_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.verdict == VERDICT_IGNORE)
        |-> (m_beat_reg.peer_mac == 48'd0 && m_beat_reg.reply_sender_ip == 32'd0 &&
             m_beat_reg.reply_target_ip == 32'd0))
        else $error("ignored packet carries address fields");

    a_learn_no_ips : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.verdict == VERDICT_LEARN)
        |-> (m_beat_reg.reply_sender_ip == 32'd0 && m_beat_reg.reply_target_ip == 32'd0))
        else $error("learn-only result carries reply addresses");

    a_no_result_mid_packet : assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !s_payload.last_byte && m_ready) |=> !m_valid_reg)
        else $error("result raised by a beat that is not the last");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import parp_pkg::*;

    localparam int CycleLimit = 200_000;
    localparam int BytesPerPhase = 150;
    localparam int RandomPhases = 7;
    localparam logic [CfgIndexW-1:0] CFG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_payload;
    logic cfg_wr_en = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = CFG_WAN_ADDRESS;
    logic [31:0] cfg_data = '0;

    in_beat_t byte_queue[$];
    out_beat_t arp_results[$];
    bit no_idle = 1'b0;
    int packet_bytes = 0;
    int results_seen = 0;
    int fault_count = 0;
    int cycle_count = 0;

    logic [31:0] wan_cfg = '0;
    logic [31:0] lan_cfg = '0;
    logic [31:0] gw_cfg = '0;

    logic [CountW-1:0] byte_count = '0;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [7:0] hw_len = '0;
    logic [7:0] proto_len = '0;
    logic [15:0] opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic [47:0] client_mac = '0;
    logic client_known = 1'b0;

    proxy_arp_responder_unit u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [1:0] arp_verdict();
        logic header_ok;
        header_ok = byte_count == HdrBytes &&
                    (hw_type == HW_ETHERNET || hw_type == HW_IEEE802) &&
                    proto_type == PROTO_IPV4 && hw_len == MAC_LEN && proto_len == IP_LEN &&
                    sender_ip != 32'd0;
        if (!header_ok) begin
            return VERDICT_IGNORE;
        end
        if (opcode == OP_REQUEST) begin
            if (wan_cfg == 32'd0) begin
                return (sender_ip != target_ip) ? VERDICT_REPLY : VERDICT_IGNORE;
            end
            if (sender_ip == wan_cfg && ((target_ip ^ wan_cfg) & lan_cfg) == 32'd0 &&
                target_ip != wan_cfg) begin
                return VERDICT_REPLY;
            end
            return VERDICT_IGNORE;
        end
        if (opcode == OP_REPLY && sender_ip == wan_cfg && target_ip == gw_cfg) begin
            return VERDICT_LEARN;
        end
        return VERDICT_IGNORE;
    endfunction

    // Fields shift in (target MAC and bytes past the header dropped); a last byte queues the result.
    task automatic absorb_byte(input in_beat_t beat);
        out_beat_t res;
        if (byte_count < HdrBytes) begin
            if (byte_count < 2) begin
                hw_type = {hw_type[7:0], beat.data_byte};
            end else if (byte_count < 4) begin
                proto_type = {proto_type[7:0], beat.data_byte};
            end else if (byte_count == 4) begin
                hw_len = beat.data_byte;
            end else if (byte_count == 5) begin
                proto_len = beat.data_byte;
            end else if (byte_count < 8) begin
                opcode = {opcode[7:0], beat.data_byte};
            end else if (byte_count < 14) begin
                sender_mac = {sender_mac[39:0], beat.data_byte};
            end else if (byte_count < 18) begin
                sender_ip = {sender_ip[23:0], beat.data_byte};
            end else if (byte_count >= 24) begin
                target_ip = {target_ip[23:0], beat.data_byte};
            end
            byte_count++;
        end
        if (beat.last_byte) begin
            res = '0;
            res.verdict = arp_verdict();
            if (res.verdict != VERDICT_IGNORE) begin
                res.peer_mac = sender_mac;
                client_mac = sender_mac;
                client_known = 1'b1;
            end
            if (res.verdict == VERDICT_REPLY) begin
                res.reply_sender_ip = target_ip;
                res.reply_target_ip = wan_cfg;
            end
            arp_results.push_back(res);
            byte_count = '0;
        end
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        results_seen++;
        if (arp_results.size() == 0) begin
            report_fault($sformatf("result %0d arrived with none expected: %h",
                                   results_seen, got));
            return;
        end
        want = arp_results.pop_front();
        if (got.verdict !== want.verdict)
            report_fault($sformatf("result %0d verdict: expected %0d, got %0d",
                                   results_seen, want.verdict, got.verdict));
        if (got.reply_sender_ip !== want.reply_sender_ip)
            report_fault($sformatf("result %0d reply_sender_ip: expected %h, got %h",
                                   results_seen, want.reply_sender_ip, got.reply_sender_ip));
        if (got.reply_target_ip !== want.reply_target_ip)
            report_fault($sformatf("result %0d reply_target_ip: expected %h, got %h",
                                   results_seen, want.reply_target_ip, got.reply_target_ip));
        if (got.peer_mac !== want.peer_mac)
            report_fault($sformatf("result %0d peer_mac: expected %h, got %h",
                                   results_seen, want.peer_mac, got.peer_mac));
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    task automatic queue_packet(input logic [15:0] hw, input logic [15:0] proto,
                                input logic [7:0] hlen, input logic [7:0] plen,
                                input logic [15:0] op, input logic [47:0] smac,
                                input logic [31:0] sip, input logic [31:0] tip,
                                input int len);
        logic [223:0] hdr;
        in_beat_t beat;
        hdr = {hw, proto, hlen, plen, op, smac, sip, rand_mac(), tip};
        for (int i = 0; i < len; i++) begin
            beat.data_byte = (i < HdrBytes) ? hdr[223 - 8 * i -: 8] : 8'($urandom);
            beat.last_byte = (i == len - 1);
            byte_queue.push_back(beat);
        end
        packet_bytes += len;
    endtask

    task automatic queue_request(input logic [47:0] smac, input logic [31:0] sip,
                                 input logic [31:0] tip);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, smac, sip, tip,
                     HdrBytes);
    endtask

    task automatic queue_reply(input logic [31:0] sip, input logic [31:0] tip);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REPLY, rand_mac(), sip,
                     tip, HdrBytes);
    endtask

    task automatic queue_noise();
        in_beat_t beat;
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            beat.data_byte = 8'($urandom);
            beat.last_byte = (i == n - 1) || ($urandom_range(7) == 0);
            byte_queue.push_back(beat);
        end
    endtask

    task automatic queue_random_packet();
        logic [15:0] hw;
        logic [15:0] proto;
        logic [7:0] hlen;
        logic [7:0] plen;
        logic [15:0] op;
        logic [31:0] sip;
        logic [31:0] tip;
        int len;
        hw = $urandom_range(1) ? HW_ETHERNET : HW_IEEE802;
        proto = PROTO_IPV4;
        hlen = MAC_LEN;
        plen = IP_LEN;
        len = HdrBytes;
        op = $urandom_range(1) ? OP_REQUEST : OP_REPLY;
        if (op == OP_REQUEST) begin
            if (wan_cfg == 32'd0) begin
                sip = $urandom;
                tip = ($urandom_range(4) == 0) ? sip : $urandom;
            end else begin
                sip = ($urandom_range(4) == 0) ? $urandom : wan_cfg;
                case ($urandom_range(5))
                    0: tip = wan_cfg;
                    1: tip = $urandom;
                    default: tip = (wan_cfg & lan_cfg) | ($urandom & ~lan_cfg);
                endcase
            end
        end else begin
            sip = ($urandom_range(4) == 0) ? $urandom : wan_cfg;
            tip = ($urandom_range(3) == 0) ? $urandom : gw_cfg;
        end
        case ($urandom_range(29))
            0: hw = 16'($urandom);
            1: proto = 16'($urandom);
            2: hlen = 8'($urandom);
            3: plen = 8'($urandom);
            4: op = 16'($urandom);
            5: sip = 32'd0;
            6: len = $urandom_range(1, HdrBytes - 1);
            7: len = $urandom_range(HdrBytes + 1, 40);
            default: ;
        endcase
        queue_packet(hw, proto, hlen, plen, op, rand_mac(), sip, tip, len);
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || s_valid || arp_results.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_WAN_ADDRESS: wan_cfg = value;
            CFG_LAN_MASK: lan_cfg = value;
            CFG_GATEWAY_ADDRESS: gw_cfg = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] wan, input logic [31:0] mask,
                              input logic [31:0] gw);
        drain();
        write_reg(CFG_WAN_ADDRESS, wan);
        write_reg(CFG_LAN_MASK, mask);
        write_reg(CFG_GATEWAY_ADDRESS, gw);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(s_payload);
            end
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && (no_idle || $urandom_range(99) >= 25)) begin
                    s_payload <= byte_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
            m_ready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("proxy_arp_responder_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] wan;
        logic [31:0] mask;
        logic [31:0] gw;
        int stop;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_config(32'h0A00_0005, 32'hFFFF_FF00, 32'h0A00_0001);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, '1,
                     32'h0A00_0005, 32'h0A00_00FE, HdrBytes);
        queue_packet(HW_IEEE802, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, '0,
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_request(rand_mac(), 32'h0A00_0005, 32'h0A00_0005);
        queue_request(rand_mac(), 32'h0A00_0005, 32'h0B00_0007);
        queue_request(rand_mac(), 32'h0A00_0009, 32'h0A00_0007);
        queue_reply(32'h0A00_0005, 32'h0A00_0001);
        queue_reply(32'h0A00_0005, 32'h0A00_0002);
        queue_packet(16'hFFFF, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_packet(HW_ETHERNET, 16'h86DD, MAC_LEN, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_packet(HW_ETHERNET, PROTO_IPV4, 8'hFF, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, 8'h00, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, 16'h0000, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, 16'hFFFF, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes);
        queue_request(rand_mac(), 32'h0000_0000, 32'h0A00_0007);
        queue_packet('0, '0, '0, '0, '0, '0, '0, '0, HdrBytes);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, HdrBytes - 1);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, 1);
        queue_packet(HW_ETHERNET, PROTO_IPV4, MAC_LEN, IP_LEN, OP_REQUEST, rand_mac(),
                     32'h0A00_0005, 32'h0A00_0007, 40);

        // With the WAN down any valid request with a nonzero sender that is not an announcement gets a reply.
        set_config(32'h0000_0000, 32'hFFFF_FF00, 32'h0A00_0001);
        queue_request(rand_mac(), 32'hC0A8_0102, 32'hC0A8_0101);
        queue_request(rand_mac(), 32'hC0A8_0102, 32'hC0A8_0102);
        queue_reply(32'h0000_0000, 32'h0A00_0001);

        set_config('1, '1, '1);
        write_reg(CFG_UNUSED, $urandom);
        @(negedge aclk);
        queue_request(rand_mac(), 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_reply(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        set_config('1, '0, '0);
        queue_request(rand_mac(), 32'hFFFF_FFFF, 32'h0000_0000);
        queue_reply(32'hFFFF_FFFF, 32'h0000_0000);

        for (int p = 0; p < RandomPhases; p++) begin
            case ($urandom_range(4))
                0: wan = '0;
                1: wan = '1;
                default: wan = $urandom;
            endcase
            case ($urandom_range(3))
                0: mask = '0;
                1: mask = '1;
                default: mask = 32'hFFFF_FFFF << $urandom_range(8, 30);
            endcase
            case ($urandom_range(3))
                0: gw = '0;
                1: gw = '1;
                default: gw = $urandom;
            endcase
            set_config(wan, mask, gw);
            no_idle = (p == 3);
            stop = packet_bytes + BytesPerPhase;
            while (packet_bytes < stop) begin
                if ($urandom_range(9) == 0) begin
                    queue_noise();
                end else begin
                    queue_random_packet();
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fault_count == 0) begin
            $display("proxy_arp_responder_unit regression: pass");
        end else begin
            $display("proxy_arp_responder_unit regression: fail");
        end
        $finish;
    end

endmodule
